// ===== design/iir3_pkg.sv =====
// ----------------------------------------------------------------------------
// iir3_pkg: shared types and constants of the third-order tone filter
// Sample, coefficient and accumulator widths, register indexes, item structs.
// ----------------------------------------------------------------------------
package iir3_pkg;

    // Number of channels with their own history
    localparam int CHANNELS = 2;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Data widths
    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 18;
    localparam int FRAC_BITS = 14;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + 3;   // seven terms
    localparam int TAPS      = 3;

    // Configuration register indexes
    localparam int NUM_COEF = 7;
    localparam int IDX_W    = 3;
    localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_B3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_A1 = 3'd4;
    localparam logic [IDX_W-1:0] REG_A2 = 3'd5;
    localparam logic [IDX_W-1:0] REG_A3 = 3'd6;

    // Reset value of b0: 1.0 in Q3.14
    localparam logic signed [COEF_W-1:0] COEF_B0_RESET = COEF_W'(1 << FRAC_BITS);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       chan_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       chan_out;
        logic                       clipped;
    } out_item_t;

endpackage

// ===== design/third_order_iir_tone_filter_core.sv =====
// ----------------------------------------------------------------------------
// third_order_iir_tone_filter_core: third-order direct-form-I filter
// Per-channel input and output history, Q3.14 coefficients, rounded and
// saturated 24-bit result with a clip flag.
// ----------------------------------------------------------------------------
//
//  channel   signals                        direction   accepted when
//  input     in_valid, in_stall, in_data    in          in_valid && !in_stall
//  output    out_valid, out_stall, out_data out         out_valid && !out_stall
//  config    cfg_we, cfg_index, cfg_data    in          cfg_we
//
//  An item goes from acceptance into the input register, then through the
//  seven multipliers, the adder tree, rounding and saturation into the result
//  register. A new item is taken every cycle while the output does not stall.
//  The histories update at the edge where an item enters the result register,
//  so the next item of the same channel sees them at once.
//  Reset clears the coefficients to b0 = 1.0 and all others to zero, and
//  clears both histories. A stall at the output holds the result register and
//  then the input register; in_stall rises only when both are full.
//
module third_order_iir_tone_filter_core
    import iir3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,

    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,

    input  logic                  cfg_we,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [COEF_W-1:0]     cfg_data
);

    // Saturation bounds at accumulator width
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));

    // Coefficients: b0..b3, a1..a3
    coef_t     coef_reg [NUM_COEF];

    // Histories: index 0 is one step back
    sample_t   xh_reg [CHANNELS][TAPS];
    sample_t   yh_reg [CHANNELS][TAPS];

    // Input and result registers
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic      advance;
    logic      in_take;

    logic [CH_W-1:0]            ch;
    logic signed [PROD_W-1:0]   prod [NUM_COEF];
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    rounded;
    sample_t                    sat_next;
    logic                       clip_next;
    out_item_t                  out_item_next;

    // Move the input register on whenever the result register is free or drains
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Fold the channel number onto the available histories
    assign ch = (CHANNELS == 1) ? '0 : CH_W'(in_item_reg.chan_in);

    always_comb
    begin
        prod[0] = PROD_W'(coef_reg[REG_B0]) * PROD_W'(in_item_reg.sample_in);
        prod[1] = PROD_W'(coef_reg[REG_B1]) * PROD_W'(xh_reg[ch][0]);
        prod[2] = PROD_W'(coef_reg[REG_B2]) * PROD_W'(xh_reg[ch][1]);
        prod[3] = PROD_W'(coef_reg[REG_B3]) * PROD_W'(xh_reg[ch][2]);
        prod[4] = PROD_W'(coef_reg[REG_A1]) * PROD_W'(yh_reg[ch][0]);
        prod[5] = PROD_W'(coef_reg[REG_A2]) * PROD_W'(yh_reg[ch][1]);
        prod[6] = PROD_W'(coef_reg[REG_A3]) * PROD_W'(yh_reg[ch][2]);

        acc = ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'(prod[2]) + ACC_W'(prod[3])
            - ACC_W'(prod[4]) - ACC_W'(prod[5]) - ACC_W'(prod[6]);

        // Round half up, then floor-shift out the fraction
        rounded = (acc + ROUND_HALF) >>> FRAC_BITS;

        if (rounded > SAT_HI)
        begin
            sat_next  = SAT_HI[SAMPLE_W-1:0];
            clip_next = 1'b1;
        end
        else if (rounded < SAT_LO)
        begin
            sat_next  = SAT_LO[SAMPLE_W-1:0];
            clip_next = 1'b1;
        end
        else
        begin
            sat_next  = rounded[SAMPLE_W-1:0];
            clip_next = 1'b0;
        end

        out_item_next.sample_out = sat_next;
        out_item_next.chan_out   = in_item_reg.chan_in;
        out_item_next.clipped    = clip_next;
    end

    // Control state, coefficients and histories
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= (i == REG_B0) ? COEF_B0_RESET : '0;
            end
            for (int c = 0; c < CHANNELS; c++)
            begin
                for (int t = 0; t < TAPS; t++)
                begin
                    xh_reg[c][t] <= '0;
                    yh_reg[c][t] <= '0;
                end
            end
        end
        else
        begin
            if (advance)
            begin
                in_valid_reg  <= in_take;
                out_valid_reg <= in_valid_reg;
            end
            else if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end

            // Write a coefficient; drop writes past the last register
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_B0:  coef_reg[REG_B0] <= cfg_data;
                    REG_B1:  coef_reg[REG_B1] <= cfg_data;
                    REG_B2:  coef_reg[REG_B2] <= cfg_data;
                    REG_B3:  coef_reg[REG_B3] <= cfg_data;
                    REG_A1:  coef_reg[REG_A1] <= cfg_data;
                    REG_A2:  coef_reg[REG_A2] <= cfg_data;
                    REG_A3:  coef_reg[REG_A3] <= cfg_data;
                    default: ;
                endcase
            end

            // Shift the channel's histories as its item enters the result register
            if (advance && in_valid_reg)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (ch == CH_W'(c))
                    begin
                        xh_reg[c][2] <= xh_reg[c][1];
                        xh_reg[c][1] <= xh_reg[c][0];
                        xh_reg[c][0] <= in_item_reg.sample_in;
                        yh_reg[c][2] <= yh_reg[c][1];
                        yh_reg[c][1] <= yh_reg[c][0];
                        yh_reg[c][0] <= sat_next;
                    end
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
        if (advance && in_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

// ===== bench/third_order_iir_tone_filter_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// third_order_iir_tone_filter_core_test: self-checking bench of the IIR core
// Drives samples on both channels through many coefficient sets, predicts each
// filtered sample from a local copy of the coefficients and channel histories,
// and compares every result field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module third_order_iir_tone_filter_core_test;
    import iir3_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 4;     // input and result registers plus margin
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 150;
    localparam int PRESSURE_ITEMS = 60;
    localparam int LONG_HOLD      = 300;

    // Index past the last coefficient: the core must ignore writes to it
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam coef_t   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam coef_t   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam longint  ROUND_HALF = longint'(1) << (FRAC_BITS - 1);

    // Drive every input to a known value from time zero
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_item_t         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_data;
    logic             cfg_we    = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0] cfg_data = '0;

    // Filter state as the core should hold it
    coef_t   coef_shadow [NUM_COEF];
    sample_t in_hist     [CHANNELS][TAPS];
    sample_t out_hist    [CHANNELS][TAPS];

    out_item_t pending_outputs[$];   // filtered samples still owed by the core
    int        error_count       = 0;
    int        idle_cycles       = 0;
    bit        steady            = 1'b0;  // no idling on either side
    int        long_hold_cycles  = 0;     // one-shot request to the output side

    third_order_iir_tone_filter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Compute the filtered sample for one item, then shift that channel's
    // input and output histories the way the core does.
    function automatic out_item_t iir_next_output(input in_item_t it);
        longint    acc;
        longint    rounded;
        int        ch;
        bit        clip;
        out_item_t res;
        ch  = int'(it.chan_in) % CHANNELS;
        acc = longint'(coef_shadow[REG_B0]) * longint'(it.sample_in);
        for (int k = 0; k < TAPS; k++)
        begin
            acc += longint'(coef_shadow[REG_B1 + k]) * longint'(in_hist[ch][k]);
            acc -= longint'(coef_shadow[REG_A1 + k]) * longint'(out_hist[ch][k]);
        end
        // Round halves toward +infinity: add one half, then floor-shift
        rounded = (acc + ROUND_HALF) >>> FRAC_BITS;
        clip    = 1'b0;
        if (rounded > longint'(SAMPLE_MAX))
        begin
            rounded = longint'(SAMPLE_MAX);
            clip    = 1'b1;
        end
        else if (rounded < longint'(SAMPLE_MIN))
        begin
            rounded = longint'(SAMPLE_MIN);
            clip    = 1'b1;
        end
        for (int k = TAPS - 1; k > 0; k--)
        begin
            in_hist[ch][k]  = in_hist[ch][k-1];
            out_hist[ch][k] = out_hist[ch][k-1];
        end
        in_hist[ch][0]  = it.sample_in;
        // Feed back the saturated value, not the raw sum
        out_hist[ch][0] = sample_t'(rounded);
        res.sample_out  = sample_t'(rounded);
        res.chan_out    = it.chan_in;
        res.clipped     = clip;
        return res;
    endfunction

    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return sample_t'($urandom);
        else if (pick < 7)
            return sample_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        else if (pick < 9)
            return sample_t'(int'($urandom_range(0, 1024)) - 512);
        case ($urandom_range(0, 3))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one item after a random gap and hold it until the core takes it.
    // Valid stays high after acceptance so back-to-back items need no toggle;
    // settle() drops it before anything else happens on the bus.
    task automatic send_sample(input sample_t smp, input logic chan);
        in_item_t it;
        int       gap;
        it.sample_in = smp;
        it.chan_in   = chan;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        pending_outputs.push_back(iir_next_output(it));
    endtask

    // Drop valid, wait for every owed result, then let the pipeline empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; the caller lowers the write enable afterwards.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input coef_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx < NUM_COEF)
            coef_shadow[idx] = value;
    endtask

    task automatic load_filter(input coef_t b0, input coef_t b1, input coef_t b2,
                               input coef_t b3, input coef_t a1, input coef_t a2,
                               input coef_t a3);
        settle();
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_B3, b3);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
        write_reg(REG_A3, a3);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Output side: stall for a random count per item, honor long holds
    // ------------------------------------------------------------------------
    initial
    begin : result_drain
        int hold;
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 12);
            if (long_hold_cycles > 0)
            begin
                hold             = long_hold_cycles;
                long_hold_cycles = 0;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outputs.size() == 0)
                report_mismatch($sformatf("result %0d on channel %0d with nothing owed",
                                          out_data.sample_out, out_data.chan_out));
            else
            begin
                want = pending_outputs.pop_front();
                if (out_data.sample_out !== want.sample_out)
                    report_mismatch($sformatf("sample_out %0d, predicted %0d",
                                              out_data.sample_out, want.sample_out));
                if (out_data.chan_out !== want.chan_out)
                    report_mismatch($sformatf("chan_out %0b, predicted %0b",
                                              out_data.chan_out, want.chan_out));
                if (out_data.clipped !== want.clipped)
                    report_mismatch($sformatf("clipped %0b, predicted %0b (sample %0d)",
                                              out_data.clipped, want.clipped,
                                              want.sample_out));
            end
        end
    end

    // Count cycles without any handshake; a hung core ends the run here
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset coefficients give b0 = 1.0: every sample must come back unchanged
    task automatic test_unity_passthrough();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        send_sample(sample_t'(1), 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
    endtask

    // A write past the last coefficient must leave the filter as it was
    task automatic test_spare_register();
        settle();
        write_reg(REG_SPARE, coef_t'($urandom));
        cfg_we <= 1'b0;
        send_sample(sample_t'(12345), 1'b1);
        send_sample(sample_t'(-54321), 1'b0);
    endtask

    // b0 = 0.5 puts odd samples on an exact half: halves go toward +infinity
    task automatic test_rounding();
        load_filter(coef_t'(1 << (FRAC_BITS - 1)), '0, '0, '0, '0, '0, '0);
        send_sample(sample_t'(1), 1'b0);
        send_sample(sample_t'(-1), 1'b1);
        send_sample(sample_t'(3), 1'b0);
        send_sample(sample_t'(-3), 1'b1);
    endtask

    // Largest gains on full-scale samples clip at both rails
    task automatic test_saturation();
        load_filter(COEF_MAX, '0, '0, '0, '0, '0, '0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        load_filter(COEF_MIN, '0, '0, '0, '0, '0, '0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
    endtask

    // Every tap at an extreme, histories full of rail values
    task automatic test_extreme_taps();
        load_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        load_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
    endtask

    // Random coefficient sets of several flavors, random samples on both
    // channels; every third phase runs with no idling at all.
    task automatic test_random_filters();
        coef_t c [NUM_COEF];
        for (int phase = 0; phase < PHASES; phase++)
        begin
            for (int r = 0; r < NUM_COEF; r++)
            begin
                case (phase % 5)
                    0: c[r] = coef_t'($urandom);
                    1: c[r] = (r < REG_A1) ? coef_t'(int'($urandom_range(0, 8192)) - 4096)
                                           : coef_t'(int'($urandom_range(0, 4096)) - 2048);
                    2: c[r] = (r < REG_A1) ? coef_t'($urandom) : coef_t'(0);
                    3: case ($urandom_range(0, 2))
                           0:       c[r] = COEF_MAX;
                           1:       c[r] = COEF_MIN;
                           default: c[r] = '0;
                       endcase
                    default: c[r] = (r == REG_B0 || r >= REG_A1) ? coef_t'($urandom)
                                                                 : coef_t'(0);
                endcase
            end
            load_filter(c[REG_B0], c[REG_B1], c[REG_B2], c[REG_B3],
                        c[REG_A1], c[REG_A2], c[REG_A3]);
            steady = (phase % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(random_sample(), logic'($urandom_range(0, 1)));
            steady = 1'b0;
        end
    endtask

    // Hold the output off for a long stretch while items keep coming, so the
    // pipeline fills and the core must stall its input.
    task automatic test_backpressure();
        load_filter(coef_t'(int'($urandom_range(0, 16384)) - 8192),
                    coef_t'(int'($urandom_range(0, 8192)) - 4096),
                    coef_t'(int'($urandom_range(0, 8192)) - 4096),
                    coef_t'(int'($urandom_range(0, 8192)) - 4096),
                    coef_t'(int'($urandom_range(0, 4096)) - 2048),
                    coef_t'(int'($urandom_range(0, 4096)) - 2048),
                    coef_t'(int'($urandom_range(0, 4096)) - 2048));
        steady           = 1'b1;
        long_hold_cycles = LONG_HOLD;
        for (int n = 0; n < PRESSURE_ITEMS; n++)
            send_sample(random_sample(), logic'($urandom_range(0, 1)));
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        // Mirror the reset state: unity b0, everything else clear
        for (int r = 0; r < NUM_COEF; r++)
            coef_shadow[r] = '0;
        coef_shadow[REG_B0] = COEF_B0_RESET;
        for (int ch = 0; ch < CHANNELS; ch++)
            for (int k = 0; k < TAPS; k++)
            begin
                in_hist[ch][k]  = '0;
                out_hist[ch][k] = '0;
            end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unity_passthrough();
        test_spare_register();
        test_rounding();
        test_saturation();
        test_extreme_taps();
        test_random_filters();
        test_backpressure();

        // Wait out every owed result and watch for strays
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
design/iir3_pkg.sv
design/third_order_iir_tone_filter_core.sv
bench/third_order_iir_tone_filter_core_test.sv
